FILE: hw/rtl/kbd_fifo_pkg.sv
// Shared key codes, field widths and the scancode to ASCII mapping function.
package kbd_fifo_pkg;

    localparam int CHAR_W      = 8;
    localparam int CODE_W      = 8;
    localparam int IN_TDATA_W  = 16;

    localparam logic [CODE_W-1:0] KEY_A         = 8'd4;
    localparam logic [CODE_W-1:0] KEY_Z         = 8'd29;
    localparam logic [CODE_W-1:0] KEY_ONE       = 8'd30;
    localparam logic [CODE_W-1:0] KEY_NINE      = 8'd38;
    localparam logic [CODE_W-1:0] KEY_EIGHT     = 8'd37;
    localparam logic [CODE_W-1:0] KEY_ZERO      = 8'd39;
    localparam logic [CODE_W-1:0] KEY_RETURN    = 8'd40;
    localparam logic [CODE_W-1:0] KEY_ESCAPE    = 8'd41;
    localparam logic [CODE_W-1:0] KEY_SPACE     = 8'd44;
    localparam logic [CODE_W-1:0] KEY_EQUALS    = 8'd46;
    localparam logic [CODE_W-1:0] KEY_SEMICOLON = 8'd51;
    localparam logic [CODE_W-1:0] KEY_PERIOD    = 8'd55;
    localparam logic [CODE_W-1:0] KEY_LSHIFT    = 8'd225;
    localparam logic [CODE_W-1:0] KEY_RSHIFT    = 8'd229;

    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0] ASCII_ONE     = 8'd49;
    localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] ASCII_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] ASCII_NUL     = 8'h00;

    // Map a key usage code to ASCII; unmapped codes give NUL.
    function automatic logic [CHAR_W-1:0] map_key(input logic [CODE_W-1:0] code,
                                                  input logic              shifted);
        logic [CHAR_W-1:0] ch;
        ch = ASCII_NUL;
        if (code == KEY_SPACE) begin
            ch = ASCII_SPACE;
        end else if (code == KEY_RETURN) begin
            ch = ASCII_CR;
        end else if (code >= KEY_A && code <= KEY_Z) begin
            ch = (shifted ? ASCII_UPPER_A : ASCII_LOWER_A) + (code - KEY_A);
        end else if (!shifted) begin
            if (code >= KEY_ONE && code <= KEY_NINE) begin
                ch = ASCII_ONE + (code - KEY_ONE);
            end else if (code == KEY_EQUALS) begin
                ch = 8'(int'("="));
            end else if (code == KEY_ZERO) begin
                ch = 8'(int'("0"));
            end else if (code == KEY_PERIOD) begin
                ch = 8'(int'("."));
            end else if (code == KEY_SEMICOLON) begin
                ch = 8'(int'(";"));
            end
        end else begin
            if (code == KEY_EQUALS) begin
                ch = 8'(int'("+"));
            end else if (code == KEY_EIGHT) begin
                ch = 8'(int'("*"));
            end else if (code == KEY_PERIOD) begin
                ch = 8'(int'(">"));
            end else if (code == KEY_SEMICOLON) begin
                ch = 8'(int'(":"));
            end
        end
        return ch;
    endfunction

endpackage

FILE: hw/rtl/keyboard_scancode_to_ascii_fifo.sv
// Key event to ASCII converter with a character FIFO, stream in and out.
// Each accepted item's result is registered in the output register. Throughput: one
// item per cycle unless the output stalls; the FIFO head comes from the registered
// RAM read, kept one step ahead with a bypass for a write to the next read address.
// Reset (i_rst_n low, synchronous) clears shift, pointers, fill count and output
// valid; character storage is not cleared and needs no clearing pass.
module keyboard_scancode_to_ascii_fifo
    import kbd_fifo_pkg::*;
#(
    parameter int FIFO_DEPTH   = 64,
    localparam int AW          = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1),
    localparam int OUT_TDATA_W = ((2 + CHAR_W + CNT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tdata: [0] key_down, [8:1] scancode
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: [0] mode
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: [0] pushed, [1] overflow, [9:2] pop_char, then fill_count
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready
);

    localparam logic [AW-1:0]    PTR_LAST = AW'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    logic              r_shift;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_byp_valid, n_byp_valid;
    logic [CHAR_W-1:0] r_byp_data;
    logic              r_out_valid;
    logic              r_out_pushed, r_out_overflow;
    logic [CHAR_W-1:0] r_out_char;
    logic [CNT_W-1:0]  r_out_count;

    logic              in_mode, in_down;
    logic [CODE_W-1:0] in_code;
    logic              accept, is_shift_key, do_map, full, wr_en, rd_en;
    logic [CHAR_W-1:0] map_char, ram_q, head_char;

    assign in_mode = s_axis_tuser;
    assign in_down = s_axis_tdata[0];
    assign in_code = s_axis_tdata[CODE_W:1];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign is_shift_key = (in_code == KEY_LSHIFT) || (in_code == KEY_RSHIFT);
    assign do_map       = !in_mode && !is_shift_key && in_down && (in_code != KEY_ESCAPE);
    assign full         = (r_count == CNT_FULL);
    assign wr_en        = accept && do_map && !full;
    assign rd_en        = accept && in_mode && (r_count != '0);
    assign map_char     = map_key(in_code, r_shift);

    assign n_rd_ptr = !rd_en ? r_rd_ptr : ((r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1);
    assign n_wr_ptr = !wr_en ? r_wr_ptr : ((r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1);

    always_comb begin
        n_count = r_count;
        if (wr_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    // Forward a write that lands on the next head slot; the RAM returns old data then.
    assign n_byp_valid = wr_en && (r_wr_ptr == n_rd_ptr);
    assign head_char   = r_byp_valid ? r_byp_data : ram_q;

    kbd_fifo_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(FIFO_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_wr_ptr),
        .i_wdata(map_char),
        .i_raddr(n_rd_ptr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= 1'b0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_byp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_count     <= n_count;
            r_byp_valid <= n_byp_valid;
            if (accept && !in_mode && is_shift_key) begin
                r_shift <= in_down;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= map_char;
        if (accept) begin
            r_out_pushed   <= wr_en;
            r_out_overflow <= do_map && full;
            r_out_char     <= rd_en ? head_char : ASCII_NUL;
            r_out_count    <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_count, r_out_char, r_out_overflow, r_out_pushed});

endmodule

FILE: hw/rtl/kbd_fifo_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
module kbd_fifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/kbd_fifo_checker.sv
// Port-level checks for the scancode FIFO, bound to the top level.
module kbd_fifo_checker
    import kbd_fifo_pkg::*;
#(
    parameter int FIFO_DEPTH   = 64,
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1),
    localparam int OUT_TDATA_W = ((2 + CHAR_W + CNT_W + 7) / 8) * 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready
);

    logic              o_pushed, o_overflow;
    logic [CHAR_W-1:0] o_char;
    logic [CNT_W-1:0]  o_count;

    assign o_pushed   = m_axis_tdata[0];
    assign o_overflow = m_axis_tdata[1];
    assign o_char     = m_axis_tdata[CHAR_W+1:2];
    assign o_count    = m_axis_tdata[CHAR_W+CNT_W+1:CHAR_W+2];

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_push_xor_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(o_pushed && o_overflow))
        else $error("pushed and overflow both set");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && o_overflow |-> o_count == CNT_W'(FIFO_DEPTH))
        else $error("overflow reported while FIFO not full");

    a_pop_char_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (o_char != ASCII_NUL) |-> !o_pushed && !o_overflow)
        else $error("character popped on a key event");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

endmodule

bind keyboard_scancode_to_ascii_fifo kbd_fifo_checker #(
    .FIFO_DEPTH(FIFO_DEPTH)
) u_kbd_fifo_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
);
